// File: sv/lpht_pkg.sv
// Shared types and constants of the linear-probing hash join table.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package lpht_pkg;

  localparam int BUCKETS_DEF = 1024;

  localparam int KEY_W   = 64;
  localparam int TOTAL_W = 64;
  localparam int COUNT_W = 11;
  localparam int CFG_W   = 4;

  localparam logic [KEY_W-1:0]   HASH_MUL  = 64'h01B6_9B4B_ACD0_5F15;
  localparam logic [KEY_W-1:0]   EMPTY_KEY = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [CFG_W-1:0]   LOG2_RST  = 4'd11;
  localparam logic [CFG_W-1:0]   LOG2_MIN  = 4'd2;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 11'd2047;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_PROBE  = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_FULL     = 2'd1,
    ST_RESERVED = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_WALK,
    S_OUT
  } state_t;

endpackage

`default_nettype wire

// File: sv/lpht_hash.sv
// Start bucket of a key: bits of key times the odd hash constant, masked.
// Depends on lpht_pkg for the hash constant.
`timescale 1ns / 1ps
`default_nettype none

module lpht_hash
  import lpht_pkg::*;
#(
  parameter int PAW = 10
) (
  input  wire logic [PAW:0]   key_lo,
  input  wire logic [PAW-1:0] mask,
  output logic      [PAW-1:0] start
);

  // Only the low PAW+1 product bits reach the bucket index, and those depend
  // only on the low PAW+1 bits of each factor.
  logic [PAW:0] prod;

  assign prod  = key_lo * HASH_MUL[PAW:0];
  assign start = prod[PAW:1] & mask;

endmodule

`default_nettype wire

// File: sv/lpht_table_mem.sv
// Key and payload columns of the table, one synchronous memory each.
// Reads are registered; depends on lpht_pkg for widths.
`timescale 1ns / 1ps
`default_nettype none

module lpht_table_mem
  import lpht_pkg::*;
#(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  wire logic             clk,
  input  wire logic             key_we,
  input  wire logic             pay_we,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [KEY_W-1:0] wr_key,
  input  wire logic [KEY_W-1:0] wr_payload,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [KEY_W-1:0] rd_key
);

  logic [KEY_W-1:0] key_mem [DEPTH];
  logic [KEY_W-1:0] pay_mem [DEPTH];
  logic [KEY_W-1:0] rd_key_r;

  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[wr_addr] <= wr_key;
    end
    rd_key_r <= key_mem[rd_addr];
  end

  // The payload column is kept beside the keys for the join's later stages.
  always_ff @(posedge clk) begin
    if (pay_we) begin
      pay_mem[wr_addr] <= wr_payload;
    end
  end

  assign rd_key = rd_key_r;

endmodule

`default_nettype wire

// File: sv/linear_probe_hash_join_table.sv
// Top level of the linear-probing hash join table: command FSM, walk logic,
// running total and output register. Uses lpht_pkg, lpht_hash, lpht_table_mem.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Transfer when            Contents
// in_*      slave      in_tvalid & in_tready    command, key, payload, batch mark
// out_*     master     out_tvalid & out_tready  status, match count, total, batch mark
// cfg_*     slave      cfg_valid & cfg_ready    table_log2_slots (always ready)
//
// An insert or probe goes from its input transfer through the hash state, one
// walk state per bucket read from the single read port of the key memory, and
// the output state that loads the result, before the next input is taken.
// A rejected key or an unknown command skips the walk; a clear sweeps all
// BUCKETS entries instead. After reset the key memory is swept to empty; meanwhile
// no input is taken. A stalled output holds the finished item in the output
// register; the block still accepts and works on the next item, which then
// waits for the register before it updates the total.

module linear_probe_hash_join_table
  import lpht_pkg::*;
#(
  parameter int BUCKETS = BUCKETS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,

  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [127:0] in_tdata,   // [63:0] key, [127:64] payload
  input  wire logic [1:0]   in_tuser,   // [1:0] cmd
  input  wire logic         in_tlast,   // batch_last

  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic      [79:0]  out_tdata,  // [10:0] match_count, [74:11] match_total, zero above
  output logic      [1:0]   out_tuser,  // [1:0] status
  output logic              out_tlast,  // batch_done

  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [3:0]   cfg_data    // [3:0] table_log2_slots
);

  // Address width of the memory, and log2 of the largest power-of-two
  // bucket count that fits in it.
  localparam int AW  = $clog2(BUCKETS);
  localparam int PAW = $clog2(BUCKETS + 1) - 1;
  localparam logic [4:0]    PAW_L     = 5'(PAW);
  localparam logic [AW-1:0] SWEEP_END = AW'(BUCKETS - 1);

  state_t             state_r, state_nxt;
  logic [CFG_W-1:0]   cfg_lg_r;
  cmd_t               cmd_r, cmd_nxt;
  logic [KEY_W-1:0]   key_r, key_nxt;
  logic [KEY_W-1:0]   payload_r, payload_nxt;
  logic               last_r, last_nxt;
  logic [PAW-1:0]     walk_addr_r, walk_addr_nxt;
  logic [PAW-1:0]     steps_r, steps_nxt;
  logic [PAW:0]       count_r, count_nxt;
  status_t            status_r, status_nxt;
  logic [AW-1:0]      sweep_r, sweep_nxt;
  logic               clr_emit_r, clr_emit_nxt;
  logic [TOTAL_W-1:0] total_r, total_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [1:0]         out_status_r, out_status_nxt;
  logic [COUNT_W-1:0] out_count_r, out_count_nxt;
  logic               out_last_r, out_last_nxt;

  logic [CFG_W-1:0]   lg_clamp;
  logic [4:0]         alog_raw;
  logic [4:0]         alog;
  logic [PAW-1:0]     mask;
  logic [PAW-1:0]     start;
  logic               in_fire;
  logic               out_free;
  logic               key_reserved;
  logic               walk_empty;
  logic               walk_done;
  logic               sweep_done;
  logic [31:0]        count_ext;
  logic [COUNT_W-1:0] count_sat;

  logic               mem_key_we;
  logic               mem_pay_we;
  logic [AW-1:0]      mem_wr_addr;
  logic [KEY_W-1:0]   mem_wr_key;
  logic [AW-1:0]      mem_rd_addr;
  logic [KEY_W-1:0]   mem_rd_key;

  // Active bucket count is 2^alog: the register value less one, with small
  // values raised to the minimum and large ones capped at the memory size.
  assign lg_clamp = (cfg_lg_r < LOG2_MIN) ? LOG2_MIN : cfg_lg_r;
  assign alog_raw = 5'(lg_clamp) - 5'd1;
  assign alog     = (alog_raw > PAW_L) ? PAW_L : alog_raw;
  assign mask     = ~({PAW{1'b1}} << alog);

  assign in_tready    = (state_r == S_IDLE);
  assign in_fire      = in_tvalid && in_tready;
  assign out_free     = !out_valid_r || out_tready;
  assign cfg_ready    = 1'b1;
  assign key_reserved = (key_r == EMPTY_KEY);
  assign walk_empty   = (mem_rd_key == EMPTY_KEY);
  assign walk_done    = walk_empty || (steps_r == mask);
  assign sweep_done   = (sweep_r == SWEEP_END);

  // The full count goes into the total; the reported count saturates.
  assign count_ext = 32'(count_r);
  assign count_sat = (count_ext > 32'(COUNT_MAX)) ? COUNT_MAX : count_ext[COUNT_W-1:0];

  lpht_hash #(
    .PAW (PAW)
  ) u_hash (
    .key_lo (key_r[PAW:0]),
    .mask   (mask),
    .start  (start)
  );

  lpht_table_mem #(
    .DEPTH (BUCKETS),
    .AW    (AW)
  ) u_mem (
    .clk        (clk),
    .key_we     (mem_key_we),
    .pay_we     (mem_pay_we),
    .wr_addr    (mem_wr_addr),
    .wr_key     (mem_wr_key),
    .wr_payload (payload_r),
    .rd_addr    (mem_rd_addr),
    .rd_key     (mem_rd_key)
  );

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (sweep_done) begin
          state_nxt = clr_emit_r ? S_OUT : S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = S_HASH;
        end
      end
      S_HASH: begin
        case (cmd_r)
          CMD_CLEAR:  state_nxt = S_CLEAR;
          CMD_INSERT: state_nxt = key_reserved ? S_OUT : S_WALK;
          CMD_PROBE:  state_nxt = key_reserved ? S_OUT : S_WALK;
          default:    state_nxt = S_OUT;
        endcase
      end
      S_WALK: begin
        if (walk_done) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  // Datapath, memory control and output register loading.
  always_comb begin
    mem_key_we     = 1'b0;
    mem_pay_we     = 1'b0;
    mem_wr_addr    = AW'(walk_addr_r);
    mem_wr_key     = key_r;
    mem_rd_addr    = AW'(walk_addr_r);
    cmd_nxt        = cmd_r;
    key_nxt        = key_r;
    payload_nxt    = payload_r;
    last_nxt       = last_r;
    walk_addr_nxt  = walk_addr_r;
    steps_nxt      = steps_r;
    count_nxt      = count_r;
    status_nxt     = status_r;
    sweep_nxt      = sweep_r;
    clr_emit_nxt   = clr_emit_r;
    total_nxt      = total_r;
    out_status_nxt = out_status_r;
    out_count_nxt  = out_count_r;
    out_last_nxt   = out_last_r;
    out_valid_nxt  = out_valid_r && !out_tready;

    case (state_r)
      S_CLEAR: begin
        // One entry per cycle is marked empty.
        mem_key_we  = 1'b1;
        mem_wr_addr = sweep_r;
        mem_wr_key  = EMPTY_KEY;
        sweep_nxt   = sweep_r + 1'b1;
      end
      S_IDLE: begin
        if (in_fire) begin
          cmd_nxt     = cmd_t'(in_tuser);
          key_nxt     = in_tdata[63:0];
          payload_nxt = in_tdata[127:64];
          last_nxt    = in_tlast;
          count_nxt   = '0;
          status_nxt  = ST_DONE;
        end
      end
      S_HASH: begin
        // The first bucket read goes out straight from the hash.
        mem_rd_addr   = AW'(start);
        walk_addr_nxt = start;
        steps_nxt     = '0;
        case (cmd_r)
          CMD_CLEAR: begin
            sweep_nxt    = '0;
            clr_emit_nxt = 1'b1;
          end
          CMD_INSERT: begin
            if (key_reserved) begin
              status_nxt = ST_RESERVED;
            end
          end
          CMD_PROBE: begin
            if (key_reserved) begin
              status_nxt = ST_RESERVED;
            end
          end
          default: begin
            status_nxt = ST_DONE;
          end
        endcase
      end
      S_WALK: begin
        // mem_rd_key holds the bucket at walk_addr_r. The next bucket is read
        // in the same cycle; items never overlap, so a write here is never
        // followed by a read of the same entry before it lands.
        walk_addr_nxt = (walk_addr_r + 1'b1) & mask;
        mem_rd_addr   = AW'(walk_addr_nxt);
        steps_nxt     = steps_r + 1'b1;
        if (cmd_r == CMD_INSERT) begin
          if (walk_empty) begin
            mem_key_we = 1'b1;
            mem_pay_we = 1'b1;
            status_nxt = ST_DONE;
          end else if (walk_done) begin
            status_nxt = ST_FULL;
          end
        end else if (!walk_empty && (mem_rd_key == key_r)) begin
          count_nxt = count_r + 1'b1;
        end
      end
      S_OUT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_count_nxt  = count_sat;
          out_last_nxt   = last_r;
          case (cmd_r)
            CMD_CLEAR: total_nxt = '0;
            CMD_PROBE: total_nxt = total_r + TOTAL_W'(count_r);
            default:   total_nxt = total_r;
          endcase
        end
      end
      default: begin
        sweep_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      cfg_lg_r    <= LOG2_RST;
      sweep_r     <= '0;
      clr_emit_r  <= 1'b0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sweep_r     <= sweep_nxt;
      clr_emit_r  <= clr_emit_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        cfg_lg_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    key_r        <= key_nxt;
    payload_r    <= payload_nxt;
    last_r       <= last_nxt;
    walk_addr_r  <= walk_addr_nxt;
    steps_r      <= steps_nxt;
    count_r      <= count_nxt;
    status_r     <= status_nxt;
    out_status_r <= out_status_nxt;
    out_count_r  <= out_count_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, total_r, out_count_r};
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;

  // Outside a clear sweep, a key write only fills an empty bucket for an insert.
  a_fill_empty_only: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_key_we && (state_r != S_CLEAR)) |->
      ((cmd_r == CMD_INSERT) && (mem_rd_key == EMPTY_KEY)))
    else $error("key write outside an insert into an empty bucket");

  // A probe never counts more matches than buckets it has visited.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK) |-> (count_r <= {1'b0, steps_r}))
    else $error("match count exceeds visited buckets");

  // A finished item that finds the output register free shows up next cycle.
  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_OUT) && out_free) |=> (out_tvalid && (state_r == S_IDLE)))
    else $error("finished item not presented on the output");

endmodule

`default_nettype wire
